[hw/rtl/sts_pkg.sv]
// Shared constants and types for the sorted table search block.
package sts_pkg;

    // Default number of table entries
    localparam int TABLE_SIZE_DEF = 16;

    // Field widths
    localparam int MODE_W  = 2;
    localparam int INDEX_W = 4;
    localparam int DATA_W  = 32;
    localparam int POS_W   = 4;

    // Stream payload widths, padded to whole bytes
    localparam int S_TDATA_W = 72;   // index, value, key = 68 bits used
    localparam int M_TDATA_W = 8;    // found, position, done_res = 6 bits used

    // Item kinds carried on s_tuser; code 3 is unused
    typedef enum logic [MODE_W-1:0] {
        MODE_LOAD   = 2'd0,
        MODE_SORT   = 2'd1,
        MODE_SEARCH = 2'd2
    } mode_t;

endpackage

[hw/rtl/sorted_table_search.sv]
// Sequence: a load writes its entry in IDLE; a search does one SRCH_CMP probe per step (at most
//   clog2(N+1) probes); a sort does per outer entry: a fetch, one compare per shift, a stopping
//   compare unless the entry reaches slot 0, and one place step. Each ends in FINISH.
// Throughput: one item at a time; the next beat is taken once the result is in the
//   output register. All table accesses go through one single-port-read RAM.
// Reset: rst_n clears the controller and the output valid; table stays undefined until loaded.
module sorted_table_search
    import sts_pkg::*;
#(
    parameter int TABLE_SIZE = TABLE_SIZE_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // index[3:0], value[35:4], key[67:36], zero pad
    input  logic [MODE_W-1:0]    s_tuser,   // mode[1:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata    // found[0], position[4:1], done_res[5], zero pad
);

    localparam int AW   = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int MID0 = (TABLE_SIZE - 1) / 2;

    typedef enum logic [2:0] {
        IDLE,
        SORT_LOAD,
        SORT_CMP,
        SORT_PLACE,
        SRCH_CMP,
        FINISH
    } state_t;

    // Input field unpacking
    logic [INDEX_W-1:0]       s_index;
    logic signed [DATA_W-1:0] s_value;
    logic signed [DATA_W-1:0] s_key;

    assign s_index = s_tdata[INDEX_W-1:0];
    assign s_value = s_tdata[INDEX_W +: DATA_W];
    assign s_key   = s_tdata[INDEX_W+DATA_W +: DATA_W];

    // Registers
    state_t                   state_reg,    state_next;
    logic [AW-1:0]            outer_reg,    outer_next;
    logic [AW-1:0]            pos_reg,      pos_next;
    logic signed [DATA_W-1:0] cur_reg,      cur_next;
    logic signed [DATA_W-1:0] key_reg,      key_next;
    logic [AW:0]              lo_reg,       lo_next;
    logic [AW:0]              hi_reg,       hi_next;    // exclusive upper bound
    logic [AW-1:0]            mid_reg,      mid_next;
    logic                     found_reg,    found_next;
    logic [POS_W-1:0]         position_reg, position_next;
    logic                     done_reg,     done_next;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]     m_tdata_reg,  m_tdata_next;

    // RAM ports
    logic                     ram_we;
    logic [AW-1:0]            ram_waddr;
    logic [DATA_W-1:0]        ram_wdata;
    logic [AW-1:0]            ram_raddr;
    logic [DATA_W-1:0]        ram_rdata;
    logic signed [DATA_W-1:0] rd_val;

    // Search bound update helpers
    logic [AW:0]   srch_lo;
    logic [AW:0]   srch_hi;
    logic [AW+1:0] srch_sum;

    assign rd_val = ram_rdata;

    sts_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TABLE_SIZE),
        .AW    (AW)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Narrow the search window from the probe just read
    always_comb
    begin
        srch_lo = lo_reg;
        srch_hi = hi_reg;
        if (rd_val > key_reg)
        begin
            srch_hi = {1'b0, mid_reg};
        end
        else
        begin
            srch_lo = {1'b0, mid_reg} + (AW+1)'(1);
        end
        srch_sum = {1'b0, srch_lo} + {1'b0, srch_hi} - (AW+2)'(1);
    end

    // Controller next state
    always_comb
    begin
        state_next    = state_reg;
        outer_next    = outer_reg;
        pos_next      = pos_reg;
        cur_next      = cur_reg;
        key_next      = key_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        mid_next      = mid_reg;
        found_next    = found_reg;
        position_next = position_reg;
        done_next     = done_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        ram_we        = 1'b0;
        ram_waddr     = pos_reg;
        ram_wdata     = cur_reg;
        ram_raddr     = mid_reg;

        // Output register drains independently
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            IDLE:
            begin
                if (s_tvalid)
                begin
                    key_next      = s_key;
                    found_next    = 1'b0;
                    position_next = '0;
                    done_next     = 1'b1;
                    case (s_tuser)
                        MODE_LOAD:
                        begin
                            // Loads past the table end are dropped
                            if (32'(s_index) < TABLE_SIZE)
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = AW'(s_index);
                                ram_wdata = s_value;
                            end
                            state_next = FINISH;
                        end
                        MODE_SORT:
                        begin
                            outer_next = AW'(1);
                            ram_raddr  = AW'(1);
                            state_next = SORT_LOAD;
                        end
                        MODE_SEARCH:
                        begin
                            lo_next    = '0;
                            hi_next    = (AW+1)'(TABLE_SIZE);
                            mid_next   = AW'(MID0);
                            ram_raddr  = AW'(MID0);
                            state_next = SRCH_CMP;
                        end
                        default:
                        begin
                            // Unused kind: no operation, no completion flag
                            done_next  = 1'b0;
                            state_next = FINISH;
                        end
                    endcase
                end
            end

            // Hold the entry being inserted, fetch its left neighbor
            SORT_LOAD:
            begin
                cur_next   = rd_val;
                pos_next   = outer_reg;
                ram_raddr  = outer_reg - AW'(1);
                state_next = SORT_CMP;
            end

            // Shift larger neighbor right, or stop and place
            SORT_CMP:
            begin
                if (rd_val > cur_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = pos_reg;
                    ram_wdata = rd_val;
                    pos_next  = pos_reg - AW'(1);
                    if (pos_reg == AW'(1))
                    begin
                        state_next = SORT_PLACE;
                    end
                    else
                    begin
                        ram_raddr = pos_reg - AW'(2);
                    end
                end
                else
                begin
                    state_next = SORT_PLACE;
                end
            end

            // Drop the held entry into its slot, move to next outer entry
            SORT_PLACE:
            begin
                ram_we    = 1'b1;
                ram_waddr = pos_reg;
                ram_wdata = cur_reg;
                if (outer_reg == AW'(TABLE_SIZE - 1))
                begin
                    state_next = FINISH;
                end
                else
                begin
                    outer_next = outer_reg + AW'(1);
                    ram_raddr  = outer_reg + AW'(1);
                    state_next = SORT_LOAD;
                end
            end

            // Binary search probe
            SRCH_CMP:
            begin
                if (rd_val == key_reg)
                begin
                    found_next    = 1'b1;
                    position_next = POS_W'(mid_reg);
                    state_next    = FINISH;
                end
                else if (srch_lo < srch_hi)
                begin
                    lo_next    = srch_lo;
                    hi_next    = srch_hi;
                    mid_next   = srch_sum[AW:1];
                    ram_raddr  = srch_sum[AW:1];
                end
                else
                begin
                    state_next = FINISH;
                end
            end

            // Hand the result to the output register once it is free
            FINISH:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {2'b00, done_reg, position_reg, found_reg};
                    state_next    = IDLE;
                end
            end

            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= IDLE;
            outer_reg    <= '0;
            pos_reg      <= '0;
            cur_reg      <= '0;
            key_reg      <= '0;
            lo_reg       <= '0;
            hi_reg       <= '0;
            mid_reg      <= '0;
            found_reg    <= 1'b0;
            position_reg <= '0;
            done_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            outer_reg    <= outer_next;
            pos_reg      <= pos_next;
            cur_reg      <= cur_next;
            key_reg      <= key_next;
            lo_reg       <= lo_next;
            hi_reg       <= hi_next;
            mid_reg      <= mid_next;
            found_reg    <= found_next;
            position_reg <= position_next;
            done_reg     <= done_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
        end
    end

    assign s_tready = (state_reg == IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

[hw/rtl/sts_ram.sv]
// Generic simple dual-port RAM, one write port, one registered read port.
module sts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

[dv/sorted_table_search_test.sv]
`timescale 1ns / 100ps
// Self-checking testbench for sorted_table_search: load/sort/search/unused beats vs a software table.
module sorted_table_search_test;
    import sts_pkg::*;

    localparam int TABLE_N = TABLE_SIZE_DEF;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;
    localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;
    localparam int RANDOM_ITEMS = 1330;
    localparam int DRAIN_CYCLES = 400;
    localparam int HOLD_CYCLES  = 500;

    // Result fields in m_tdata order, lowest bit last in the list
    typedef struct packed {
        logic             done_res;
        logic [POS_W-1:0] position;
        logic             found;
    } reply_t;

    // Mirror of the table plus the replies still owed by the block
    class search_scoreboard;
        logic signed [DATA_W-1:0] entries [TABLE_N];
        reply_t awaiting [$];
        int errors;

        function new();
            errors = 0;
            foreach (entries[i])
                entries[i] = '0;
        endfunction

        // Insertion sort by adjacent swaps
        function void sort_entries();
            int pos;
            logic signed [DATA_W-1:0] held;
            for (int outer = 1; outer < TABLE_N; outer++)
            begin
                pos = outer;
                while (pos > 0 && entries[pos-1] > entries[pos])
                begin
                    held           = entries[pos-1];
                    entries[pos-1] = entries[pos];
                    entries[pos]   = held;
                    pos--;
                end
            end
        endfunction

        // Binary search, midpoint reported on a hit
        function reply_t search_entries(logic signed [DATA_W-1:0] key);
            int lo;
            int hi;
            int mid;
            reply_t r;
            r = '0;
            r.done_res = 1'b1;
            lo = 0;
            hi = TABLE_N - 1;
            while (lo <= hi)
            begin
                mid = (lo + hi) / 2;
                if (entries[mid] == key)
                begin
                    r.found    = 1'b1;
                    r.position = POS_W'(mid);
                    return r;
                end
                if (entries[mid] > key)
                    hi = mid - 1;
                else
                    lo = mid + 1;
            end
            return r;
        endfunction

        function void note_beat(logic [MODE_W-1:0] mode, logic [INDEX_W-1:0] idx,
                                logic signed [DATA_W-1:0] value,
                                logic signed [DATA_W-1:0] key);
            reply_t r;
            r = '0;
            r.done_res = 1'b1;
            case (mode)
                MODE_LOAD:   entries[idx] = value;
                MODE_SORT:   sort_entries();
                MODE_SEARCH: r = search_entries(key);
                default:     r.done_res = 1'b0;
            endcase
            awaiting.push_back(r);
        endfunction

        function void check_reply(reply_t got);
            reply_t want;
            if (awaiting.size() == 0)
            begin
                $display("%0t: unexpected result found=%0d position=%0d done_res=%0d",
                         $time, got.found, got.position, got.done_res);
                errors++;
                return;
            end
            want = awaiting.pop_front();
            if (got.found !== want.found)
            begin
                $display("%0t: found mismatch, expected %0d, got %0d",
                         $time, want.found, got.found);
                errors++;
            end
            if (got.position !== want.position)
            begin
                $display("%0t: position mismatch, expected %0d, got %0d",
                         $time, want.position, got.position);
                errors++;
            end
            if (got.done_res !== want.done_res)
            begin
                $display("%0t: done_res mismatch, expected %0d, got %0d",
                         $time, want.done_res, got.done_res);
                errors++;
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;   // index[3:0], value[35:4], key[67:36], zero pad
    logic [MODE_W-1:0]    s_tuser;   // mode[1:0]
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;   // found[0], position[4:1], done_res[5], zero pad

    search_scoreboard sb = new();
    int burst_left;

    // Table fill for the directed part: extremes, alternating bits, duplicates
    logic signed [DATA_W-1:0] seed_vals [TABLE_N] = '{
        VAL_MAX, 32'sd0, VAL_MIN, -32'sd1, 32'sh5555_5555, 32'shaaaa_aaaa, 32'sd3, 32'sd3,
        -32'sd3, 32'sd100, -32'sd100, 32'sd7, 32'sd3, 32'sd42, -32'sd42, 32'sd1
    };

    sorted_table_search #(
        .TABLE_SIZE (TABLE_N)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #10 clk = ~clk;

    // Check every accepted result beat
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && m_tvalid && m_tready)
            sb.check_reply(reply_t'(m_tdata[5:0]));
    end

    // Offer one beat, wait for the handshake, then maybe pause between bursts
    task automatic send_beat(input logic [MODE_W-1:0] mode, input logic [INDEX_W-1:0] idx,
                             input logic signed [DATA_W-1:0] value,
                             input logic signed [DATA_W-1:0] key);
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {{(S_TDATA_W - INDEX_W - 2 * DATA_W){1'b0}}, key, value, idx};
        do @(posedge clk); while (!s_tready);
        sb.note_beat(mode, idx, value, key);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(0, 8);
        end
    endtask

    // Mix of full-range, small-range (duplicates) and edge values
    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4, 5, 6:    return int'($urandom_range(0, 16)) - 8;
            7:          return VAL_MIN;
            8:          return VAL_MAX;
            default:    return $urandom_range(0, 1) ? VAL_MIN + $urandom_range(0, 3)
                                                    : VAL_MAX - $urandom_range(0, 3);
        endcase
    endfunction

    // Search keys: mostly present in the table, some just beside an entry
    function automatic logic signed [DATA_W-1:0] pick_key();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return sb.entries[$urandom_range(0, TABLE_N - 1)];
            6:                return sb.entries[$urandom_range(0, TABLE_N - 1)] + 1;
            7:                return sb.entries[$urandom_range(0, TABLE_N - 1)] - 1;
            default:          return pick_value();
        endcase
    endfunction

    // Receiver: stretches of steady, random, sparse and periodic ready, one long hold-off
    initial
    begin : receiver
        int taken;
        int stretch;
        int style;
        int period;
        bit held_off;
        m_tready <= 1'b0;
        taken    = 0;
        held_off = 1'b0;
        @(posedge rst_n);
        forever
        begin
            style   = $urandom_range(0, 3);
            stretch = $urandom_range(10, 120);
            period  = $urandom_range(2, 5);
            for (int c = 0; c < stretch; c++)
            begin
                @(posedge clk);
                if (m_tvalid && m_tready)
                    taken++;
                if (!held_off && taken >= 60)
                begin
                    held_off = 1'b1;
                    m_tready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                end
                else
                begin
                    case (style)
                        0:       m_tready <= 1'b1;
                        1:       m_tready <= 1'($urandom_range(0, 1));
                        2:       m_tready <= ($urandom_range(0, 3) == 0);
                        default: m_tready <= (c % period == 0);
                    endcase
                end
            end
        end
    end

    initial
    begin : stimulus
        int made;
        int n_loads;
        int n_searches;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tuser  <= MODE_LOAD;
        s_tdata  <= '0;
        burst_left = 4;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill every entry before any sort or search reads the table
        for (int i = 0; i < TABLE_N; i++)
            send_beat(MODE_LOAD, INDEX_W'(i), seed_vals[i], ~seed_vals[i]);
        // Search over the table while still unsorted
        send_beat(MODE_SEARCH, 4'd0, 32'sd0, 32'sd100);
        // Unused mode code
        send_beat(MODE_UNUSED, 4'hf, VAL_MAX, VAL_MIN);
        send_beat(MODE_SORT, 4'd0, 32'sd0, 32'sd0);
        // Hits at both ends and on a duplicate, misses inside the range
        send_beat(MODE_SEARCH, 4'd5, 32'sd0, VAL_MIN);
        send_beat(MODE_SEARCH, 4'd5, 32'sd0, VAL_MAX);
        send_beat(MODE_SEARCH, 4'd5, 32'sd0, 32'sd3);
        send_beat(MODE_SEARCH, 4'd5, 32'sd0, -32'sd2);
        send_beat(MODE_SEARCH, 4'd5, 32'sd0, 32'sd4);

        // Random episodes: some loads, usually a sort, then a run of searches
        made = 0;
        while (made < RANDOM_ITEMS)
        begin
            n_loads = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 16)
                                                  : $urandom_range(0, 4);
            for (int i = 0; i < n_loads; i++)
            begin
                send_beat(MODE_LOAD, INDEX_W'($urandom_range(0, TABLE_N - 1)),
                          pick_value(), $urandom);
                made++;
            end
            if ($urandom_range(0, 4) != 0)
            begin
                send_beat(MODE_SORT, INDEX_W'($urandom), $urandom, $urandom);
                made++;
            end
            n_searches = $urandom_range(1, 10);
            for (int i = 0; i < n_searches; i++)
            begin
                send_beat(MODE_SEARCH, INDEX_W'($urandom), $urandom, pick_key());
                made++;
            end
            if ($urandom_range(0, 15) == 0)
            begin
                send_beat(MODE_UNUSED, INDEX_W'($urandom), $urandom, $urandom);
                made++;
            end
        end
        s_tvalid <= 1'b0;

        // Drain, then give any stray result time to show up
        while (sb.awaiting.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("sorted_table_search_test: done, clean");
        else
            $display("sorted_table_search_test: done, errors");
        $finish;
    end

    // Hang guard
    initial
    begin
        #50_000_000;
        $display("sorted_table_search_test: done, errors");
        $finish;
    end

endmodule
